>>> rtl/shck_pkg.sv
// ----------------------------------------------------------------------------
// shck_pkg
// Shared types and constants of the spatial hash cell key generator: register
// indexes, reset values, key limits and the divider request/response beats.
// ----------------------------------------------------------------------------
package shck_pkg;

  // Fixed widths of the coordinate and register fields
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CELL_W  = 31;
  localparam int unsigned TSIZE_W = 21;
  localparam int unsigned MULT_W  = 32;
  localparam int unsigned PRIM_W  = 16;
  localparam int unsigned KEY_W   = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Default span limit per axis, in cells
  localparam int unsigned SPAN_MAX_DEF = 4;

  // Key mask and bucket count limit
  localparam int unsigned KEY_BITS = 20;
  localparam logic [CELL_W-1:0] KEY_MASK = (KEY_BITS >= CELL_W) ? '1 :
                                           CELL_W'((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [TSIZE_W-1:0] TABLE_LIMIT = TSIZE_W'(1048576);

  // Register reset values
  localparam logic [CELL_W-1:0]  CELL_RST  = CELL_W'(65536);
  localparam logic [TSIZE_W-1:0] TSIZE_RST = TSIZE_W'(1024);
  localparam logic [MULT_W-1:0]  MULT_X_RST = 32'd73856093;
  localparam logic [MULT_W-1:0]  MULT_Y_RST = 32'd19349663;
  localparam logic [MULT_W-1:0]  MULT_Z_RST = 32'd83492791;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_X = 3'd0,
    CFG_CELL_Y = 3'd1,
    CFG_CELL_Z = 3'd2,
    CFG_TSIZE  = 3'd3,
    CFG_MULT_X = 3'd4,
    CFG_MULT_Y = 3'd5,
    CFG_MULT_Z = 3'd6
  } cfg_idx_e;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DIVGO   = 8'b0000_0010,
    S_DIVWAIT = 8'b0000_0100,
    S_CHECK   = 8'b0000_1000,
    S_MUL     = 8'b0001_0000,
    S_MODGO   = 8'b0010_0000,
    S_MODWAIT = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [COORD_W-1:0] dividend;
    logic [CELL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
    logic [CELL_W-1:0]  rem;
  } div_rsp_t;

endpackage

>>> rtl/shck_div.sv
// ----------------------------------------------------------------------------
// shck_div
// Restoring radix-2 unsigned divider: 32-bit dividend by a nonzero 31-bit
// divisor, one quotient bit per cycle. done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
module shck_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shck_pkg::div_req_t  req_i,
  output shck_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CNT_W = $clog2(shck_pkg::COORD_W);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [shck_pkg::COORD_W-1:0]  dq_q, dq_d;
  logic [shck_pkg::CELL_W-1:0]   rem_q, rem_d;
  logic [shck_pkg::CELL_W-1:0]   dvs_q, dvs_d;

  // one restoring step
  logic [shck_pkg::COORD_W-1:0]  trial;
  logic [shck_pkg::COORD_W-1:0]  diff;
  logic                          ge;

  assign trial = {rem_q, dq_q[shck_pkg::COORD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      dq_d  = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      dq_d  = {dq_q[shck_pkg::COORD_W-2:0], ge};
      rem_d = ge ? diff[shck_pkg::CELL_W-1:0] : trial[shck_pkg::CELL_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(shck_pkg::COORD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/spatial_hash_cell_keys.sv
// Order of work: six floor divisions on the shared divider, a check state,
//   then per key three multiplies, a modulo on the same divider and one
//   output beat held by any output stall; an inverted axis ends the box at the check.
// One box at a time: in_stall_o stays high until the block is idle again.
// Reset: all control clears, the block is idle and registers take their defaults.
// ----------------------------------------------------------------------------
// spatial_hash_cell_keys
// Turns a Q16.16 bounding box into XOR-of-products hash keys, one per
// overlapped grid cell (at most SPAN_MAX per axis), walked x outermost and z innermost.
// ----------------------------------------------------------------------------
module spatial_hash_cell_keys #(
  parameter int unsigned SPAN_MAX = shck_pkg::SPAN_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [shck_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  // box input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [shck_pkg::COORD_W-1:0] box_min_x_i,
  input  logic signed [shck_pkg::COORD_W-1:0] box_min_y_i,
  input  logic signed [shck_pkg::COORD_W-1:0] box_min_z_i,
  input  logic signed [shck_pkg::COORD_W-1:0] box_max_x_i,
  input  logic signed [shck_pkg::COORD_W-1:0] box_max_y_i,
  input  logic signed [shck_pkg::COORD_W-1:0] box_max_z_i,
  input  logic [shck_pkg::PRIM_W-1:0]       prim_id_i,
  // key output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [shck_pkg::KEY_W-1:0]        bucket_key_o,
  output logic [shck_pkg::PRIM_W-1:0]       prim_tag_o,
  output logic                              last_key_o,
  output logic                              span_clamped_o
);

  localparam int unsigned OFF_W = (SPAN_MAX > 1) ? $clog2(SPAN_MAX) : 1;
  localparam int unsigned CW    = shck_pkg::COORD_W;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [shck_pkg::CELL_W-1:0]  cell_q [3];
  logic [shck_pkg::TSIZE_W-1:0] tsize_q;
  logic [shck_pkg::MULT_W-1:0]  mult_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q[0] <= shck_pkg::CELL_RST;
      cell_q[1] <= shck_pkg::CELL_RST;
      cell_q[2] <= shck_pkg::CELL_RST;
      tsize_q   <= shck_pkg::TSIZE_RST;
      mult_q[0] <= shck_pkg::MULT_X_RST;
      mult_q[1] <= shck_pkg::MULT_Y_RST;
      mult_q[2] <= shck_pkg::MULT_Z_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        shck_pkg::CFG_CELL_X: cell_q[0] <= cfg_data_i[shck_pkg::CELL_W-1:0];
        shck_pkg::CFG_CELL_Y: cell_q[1] <= cfg_data_i[shck_pkg::CELL_W-1:0];
        shck_pkg::CFG_CELL_Z: cell_q[2] <= cfg_data_i[shck_pkg::CELL_W-1:0];
        shck_pkg::CFG_TSIZE:  tsize_q   <= cfg_data_i[shck_pkg::TSIZE_W-1:0];
        shck_pkg::CFG_MULT_X: mult_q[0] <= cfg_data_i;
        shck_pkg::CFG_MULT_Y: mult_q[1] <= cfg_data_i;
        shck_pkg::CFG_MULT_Z: mult_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state
  shck_pkg::state_e state_q, state_d;
  logic [2:0]       ax_q, ax_d;     // division in flight: min x,y,z then max x,y,z
  logic [1:0]       m_q, m_d;       // axis of the product in flight
  logic             out_valid_q, out_valid_d;

  logic [CW-1:0]    box_q   [6];
  logic [shck_pkg::PRIM_W-1:0] prim_q;
  logic [CW-1:0]    start_q [3];
  logic [CW-1:0]    end_q   [3];
  logic [CW-1:0]    walk_q  [3];
  logic [OFF_W-1:0] off_q   [3];
  logic [OFF_W-1:0] eoff_q  [3];
  logic             clamp_q;
  logic [CW-1:0]    hash_q;

  logic [shck_pkg::KEY_W-1:0]  bucket_key_q;
  logic [shck_pkg::PRIM_W-1:0] prim_tag_q;
  logic                        last_key_q;
  logic                        span_clamped_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != shck_pkg::S_IDLE);

  // --------------------------------------------------------------------------
  // shared divider and its operand selection
  shck_pkg::div_req_t div_req;
  shck_pkg::div_rsp_t div_rsp;

  logic [1:0]                  ax_axis;
  logic [CW-1:0]               coord;
  logic                        coord_neg;
  logic [CW-1:0]               coord_mag;
  logic [shck_pkg::CELL_W-1:0] cell_div;
  logic [shck_pkg::CELL_W-1:0] mod_div;
  logic [CW-1:0]               floor_q;

  assign ax_axis   = (ax_q >= 3'd3) ? 2'(ax_q - 3'd3) : ax_q[1:0];
  assign coord     = box_q[ax_q];
  assign coord_neg = coord[CW-1];
  assign coord_mag = coord_neg ? (~coord + CW'(1)) : coord;
  assign cell_div  = (cell_q[ax_axis] == '0) ? shck_pkg::CELL_W'(1) : cell_q[ax_axis];

  // bucket count clamped to 1..TABLE_LIMIT
  always_comb begin
    if (tsize_q == '0) begin
      mod_div = shck_pkg::CELL_W'(1);
    end else if (tsize_q > shck_pkg::TABLE_LIMIT) begin
      mod_div = shck_pkg::CELL_W'(shck_pkg::TABLE_LIMIT);
    end else begin
      mod_div = shck_pkg::CELL_W'(tsize_q);
    end
  end

  always_comb begin
    div_req.start    = (state_q == shck_pkg::S_DIVGO) || (state_q == shck_pkg::S_MODGO);
    div_req.dividend = (state_q == shck_pkg::S_MODGO) ? hash_q : coord_mag;
    div_req.divisor  = (state_q == shck_pkg::S_MODGO) ? mod_div : cell_div;
  end

  shck_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // floor rounding for a negative dividend: -q, or -q-1 when inexact
  always_comb begin
    if (!coord_neg) begin
      floor_q = div_rsp.quot;
    end else if (div_rsp.rem != '0) begin
      floor_q = ~div_rsp.quot;
    end else begin
      floor_q = ~div_rsp.quot + CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // span check: empty axis, clamp and end offset per axis
  logic [CW:0]      span_diff [3];
  logic [2:0]       span_neg;
  logic [2:0]       span_cut;
  logic [OFF_W-1:0] span_eoff [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      span_diff[a] = {end_q[a][CW-1], end_q[a]} - {start_q[a][CW-1], start_q[a]};
      span_neg[a]  = span_diff[a][CW];
      span_cut[a]  = !span_diff[a][CW] && (span_diff[a] >= (CW+1)'(SPAN_MAX));
      span_eoff[a] = span_cut[a] ? OFF_W'(SPAN_MAX - 1) : span_diff[a][OFF_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier: one index product per cycle, folded into the hash
  logic [CW-1:0] prod;
  assign prod = walk_q[m_q] * mult_q[m_q];

  // --------------------------------------------------------------------------
  // cell walk: z steps first, carrying into y then x
  logic [CW-1:0]    walk_adv [3];
  logic [OFF_W-1:0] off_adv  [3];
  logic             at_last;

  always_comb begin
    logic carry;
    carry    = 1'b1;
    walk_adv = walk_q;
    off_adv  = off_q;
    for (int a = 2; a >= 0; a--) begin
      if (carry) begin
        if (off_q[a] == eoff_q[a]) begin
          off_adv[a]  = '0;
          walk_adv[a] = start_q[a];
        end else begin
          off_adv[a]  = off_q[a] + OFF_W'(1);
          walk_adv[a] = walk_q[a] + CW'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  assign at_last = (off_q[0] == eoff_q[0]) && (off_q[1] == eoff_q[1]) &&
                   (off_q[2] == eoff_q[2]);

  // --------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    m_d         = m_q;
    out_valid_d = out_valid_q;
    case (state_q)
      shck_pkg::S_IDLE: begin
        if (in_acc) begin
          ax_d    = '0;
          state_d = shck_pkg::S_DIVGO;
        end
      end
      shck_pkg::S_DIVGO: begin
        state_d = shck_pkg::S_DIVWAIT;
      end
      shck_pkg::S_DIVWAIT: begin
        if (div_rsp.done) begin
          if (ax_q == 3'd5) begin
            state_d = shck_pkg::S_CHECK;
          end else begin
            ax_d    = ax_q + 3'd1;
            state_d = shck_pkg::S_DIVGO;
          end
        end
      end
      shck_pkg::S_CHECK: begin
        m_d     = '0;
        state_d = (span_neg != '0) ? shck_pkg::S_IDLE : shck_pkg::S_MUL;
      end
      shck_pkg::S_MUL: begin
        if (m_q == 2'd2) begin
          state_d = shck_pkg::S_MODGO;
        end else begin
          m_d = m_q + 2'd1;
        end
      end
      shck_pkg::S_MODGO: begin
        state_d = shck_pkg::S_MODWAIT;
      end
      shck_pkg::S_MODWAIT: begin
        if (div_rsp.done) begin
          out_valid_d = 1'b1;
          state_d     = shck_pkg::S_EMIT;
        end
      end
      shck_pkg::S_EMIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          m_d         = '0;
          state_d     = last_key_q ? shck_pkg::S_IDLE : shck_pkg::S_MUL;
        end
      end
      default: begin
        state_d     = shck_pkg::S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shck_pkg::S_IDLE;
      ax_q        <= '0;
      m_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      m_q         <= m_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  always_ff @(posedge clk_i) begin
    // capture the box
    if (in_acc) begin
      box_q[0] <= box_min_x_i;
      box_q[1] <= box_min_y_i;
      box_q[2] <= box_min_z_i;
      box_q[3] <= box_max_x_i;
      box_q[4] <= box_max_y_i;
      box_q[5] <= box_max_z_i;
      prim_q   <= prim_id_i;
    end
    // cell indices from the divider
    if (state_q == shck_pkg::S_DIVWAIT && div_rsp.done) begin
      if (ax_q >= 3'd3) begin
        end_q[ax_axis] <= floor_q;
      end else begin
        start_q[ax_axis] <= floor_q;
      end
    end
    // set up the walk
    if (state_q == shck_pkg::S_CHECK) begin
      walk_q  <= start_q;
      clamp_q <= (span_cut != '0);
      hash_q  <= '0;
      for (int a = 0; a < 3; a++) begin
        off_q[a]  <= '0;
        eoff_q[a] <= span_eoff[a];
      end
    end
    // fold one product into the hash
    if (state_q == shck_pkg::S_MUL) begin
      hash_q <= hash_q ^ prod;
    end
    // remainder becomes the key
    if (state_q == shck_pkg::S_MODWAIT && div_rsp.done) begin
      bucket_key_q   <= shck_pkg::KEY_W'(div_rsp.rem & shck_pkg::KEY_MASK);
      prim_tag_q     <= prim_q;
      last_key_q     <= at_last;
      span_clamped_q <= clamp_q;
    end
    // next cell once the beat is taken
    if (state_q == shck_pkg::S_EMIT && out_acc) begin
      walk_q <= walk_adv;
      off_q  <= off_adv;
      hash_q <= '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_key_o   = bucket_key_q;
  assign prim_tag_o     = prim_tag_q;
  assign last_key_o     = last_key_q;
  assign span_clamped_o = span_clamped_q;

endmodule

>>> tb/spatial_hash_cell_keys_tb.sv
// ----------------------------------------------------------------------------
// spatial_hash_cell_keys_tb
// Drives bounding boxes into the cell key generator and checks every key
// against an in-bench model of the floor division, span clamp, cell walk and
// XOR-of-products hash. The bench runs a directed set, then random boxes under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module spatial_hash_cell_keys_tb;

  localparam int unsigned SPAN_LIMIT    = shck_pkg::SPAN_MAX_DEF;
  localparam int unsigned BATCH_BOXES   = 32;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned LONG_HOLD     = 3000;
  localparam int unsigned CYCLE_LIMIT   = 5000000;

  typedef struct packed {
    logic [shck_pkg::PRIM_W-1:0]         prim;
    logic signed [shck_pkg::COORD_W-1:0] hi_z;
    logic signed [shck_pkg::COORD_W-1:0] hi_y;
    logic signed [shck_pkg::COORD_W-1:0] hi_x;
    logic signed [shck_pkg::COORD_W-1:0] lo_z;
    logic signed [shck_pkg::COORD_W-1:0] lo_y;
    logic signed [shck_pkg::COORD_W-1:0] lo_x;
  } box_t;

  typedef struct packed {
    logic [shck_pkg::KEY_W-1:0]  bucket;
    logic [shck_pkg::PRIM_W-1:0] tag;
    logic                        last_flag;
    logic                        clamped;
  } cell_key_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // Block ports
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [shck_pkg::CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [31:0]                         cfg_data_i  = '0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  logic signed [shck_pkg::COORD_W-1:0] box_min_x_i = '0;
  logic signed [shck_pkg::COORD_W-1:0] box_min_y_i = '0;
  logic signed [shck_pkg::COORD_W-1:0] box_min_z_i = '0;
  logic signed [shck_pkg::COORD_W-1:0] box_max_x_i = '0;
  logic signed [shck_pkg::COORD_W-1:0] box_max_y_i = '0;
  logic signed [shck_pkg::COORD_W-1:0] box_max_z_i = '0;
  logic [shck_pkg::PRIM_W-1:0]         prim_id_i   = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [shck_pkg::KEY_W-1:0]          bucket_key_o;
  logic [shck_pkg::PRIM_W-1:0]         prim_tag_o;
  logic                                last_key_o;
  logic                                span_clamped_o;

  // Bench copy of the registers
  logic [shck_pkg::CELL_W-1:0]  cell_sz [3];
  logic [shck_pkg::TSIZE_W-1:0] bucket_count;
  logic [shck_pkg::MULT_W-1:0]  hash_mult [3];
  logic [31:0]                  next_cfg [7];

  box_t      box_queue [$];
  cell_key_t key_queue [$];
  box_t      cur_box;
  logic      box_taken = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_gap_left    = 0;
  int unsigned rx_gap_left    = 0;
  int unsigned rx_free_left   = 0;
  int unsigned hold_left      = 0;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen      = 0;
  logic        calm           = 1'b0;

  spatial_hash_cell_keys #(
    .SPAN_MAX(SPAN_LIMIT)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .box_min_x_i   (box_min_x_i),
    .box_min_y_i   (box_min_y_i),
    .box_min_z_i   (box_min_z_i),
    .box_max_x_i   (box_max_x_i),
    .box_max_y_i   (box_max_y_i),
    .box_max_z_i   (box_max_z_i),
    .prim_id_i     (prim_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bucket_key_o  (bucket_key_o),
    .prim_tag_o    (prim_tag_o),
    .last_key_o    (last_key_o),
    .span_clamped_o(span_clamped_o)
  );

  // Expected keys for one box: floor the corners, clamp, walk x-y-z
  function automatic void hash_box_keys(input box_t b);
    logic signed [shck_pkg::COORD_W-1:0] corner_lo [3];
    logic signed [shck_pkg::COORD_W-1:0] corner_hi [3];
    longint    first_idx [3];
    longint    last_idx [3];
    longint    cell_div;
    longint    q_lo;
    longint    q_hi;
    longint    modulus;
    logic      clamped;
    logic [31:0] ix;
    logic [31:0] iy;
    logic [31:0] iz;
    logic [31:0] mix;
    cell_key_t k;
    corner_lo[0] = b.lo_x;
    corner_lo[1] = b.lo_y;
    corner_lo[2] = b.lo_z;
    corner_hi[0] = b.hi_x;
    corner_hi[1] = b.hi_y;
    corner_hi[2] = b.hi_z;
    clamped = 1'b0;
    for (int a = 0; a < 3; a++) begin
      // a zero cell edge behaves as the smallest step
      cell_div = (cell_sz[a] == '0) ? 64'sd1 : longint'(cell_sz[a]);
      q_lo = longint'(corner_lo[a]) / cell_div;
      if (longint'(corner_lo[a]) % cell_div != 0 && corner_lo[a] < 0) q_lo--;
      q_hi = longint'(corner_hi[a]) / cell_div;
      if (longint'(corner_hi[a]) % cell_div != 0 && corner_hi[a] < 0) q_hi--;
      if (q_hi >= q_lo && q_hi - q_lo + 1 > SPAN_LIMIT) begin
        q_hi    = q_lo + SPAN_LIMIT - 1;
        clamped = 1'b1;
      end
      first_idx[a] = q_lo;
      last_idx[a]  = q_hi;
    end
    // an inverted axis gives an empty box
    for (int a = 0; a < 3; a++) begin
      if (last_idx[a] < first_idx[a]) return;
    end
    modulus = longint'(bucket_count);
    if (modulus == 0) modulus = 1;
    if (modulus > longint'(shck_pkg::TABLE_LIMIT)) modulus = longint'(shck_pkg::TABLE_LIMIT);
    for (longint x = first_idx[0]; x <= last_idx[0]; x++) begin
      for (longint y = first_idx[1]; y <= last_idx[1]; y++) begin
        for (longint z = first_idx[2]; z <= last_idx[2]; z++) begin
          ix  = 32'(x);
          iy  = 32'(y);
          iz  = 32'(z);
          mix = (ix * hash_mult[0]) ^ (iy * hash_mult[1]) ^ (iz * hash_mult[2]);
          k.bucket    = shck_pkg::KEY_W'((longint'(mix) % modulus) &
                                         ((64'sd1 <<< shck_pkg::KEY_BITS) - 1));
          k.tag       = b.prim;
          k.last_flag = (x == last_idx[0]) && (y == last_idx[1]) && (z == last_idx[2]);
          k.clamped   = clamped;
          key_queue   = {key_queue, k};
        end
      end
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Register write over the config channel; model copy follows the beat
  task automatic write_reg(input shck_pkg::cfg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      shck_pkg::CFG_CELL_X: cell_sz[0]   = value[shck_pkg::CELL_W-1:0];
      shck_pkg::CFG_CELL_Y: cell_sz[1]   = value[shck_pkg::CELL_W-1:0];
      shck_pkg::CFG_CELL_Z: cell_sz[2]   = value[shck_pkg::CELL_W-1:0];
      shck_pkg::CFG_TSIZE:  bucket_count = value[shck_pkg::TSIZE_W-1:0];
      shck_pkg::CFG_MULT_X: hash_mult[0] = value;
      shck_pkg::CFG_MULT_Y: hash_mult[1] = value;
      shck_pkg::CFG_MULT_Z: hash_mult[2] = value;
      default: ;
    endcase
  endtask

  task automatic load_setting();
    write_reg(shck_pkg::CFG_CELL_X, next_cfg[shck_pkg::CFG_CELL_X]);
    write_reg(shck_pkg::CFG_CELL_Y, next_cfg[shck_pkg::CFG_CELL_Y]);
    write_reg(shck_pkg::CFG_CELL_Z, next_cfg[shck_pkg::CFG_CELL_Z]);
    write_reg(shck_pkg::CFG_TSIZE,  next_cfg[shck_pkg::CFG_TSIZE]);
    write_reg(shck_pkg::CFG_MULT_X, next_cfg[shck_pkg::CFG_MULT_X]);
    write_reg(shck_pkg::CFG_MULT_Y, next_cfg[shck_pkg::CFG_MULT_Y]);
    write_reg(shck_pkg::CFG_MULT_Z, next_cfg[shck_pkg::CFG_MULT_Z]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every box to go in and every key to come out, then let the
  // divider finish any box that yields no key
  task automatic drain();
    while (box_queue.size() != 0 || in_valid_i || key_queue.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz,
                         input logic [shck_pkg::PRIM_W-1:0] prim);
    box_t b;
    b.lo_x = lx;
    b.lo_y = ly;
    b.lo_z = lz;
    b.hi_x = hx;
    b.hi_y = hy;
    b.hi_z = hz;
    b.prim = prim;
    box_queue = {box_queue, b};
  endtask

  // Random boxes sized in cells of the current grid: mostly a few cells,
  // some long spans, some inverted axes and some raw noise
  task automatic queue_random_boxes(input int unsigned count);
    longint lo_v [3];
    longint hi_v [3];
    longint c;
    longint k;
    int unsigned pick;
    int unsigned flip;
    for (int n = 0; n < count; n++) begin
      for (int a = 0; a < 3; a++) begin
        c = (cell_sz[a] == '0) ? 64'sd1 : longint'(cell_sz[a]);
        if ($urandom_range(0, 3) == 0) lo_v[a] = $signed($urandom);
        else lo_v[a] = longint'($urandom_range(0, 8388608)) - 4194304;
        pick = $urandom_range(0, 19);
        if (pick < 12) k = 0;
        else if (pick < 17) k = 1;
        else if (pick < 19) k = $urandom_range(2, 3);
        else k = $urandom_range(4, 30);
        hi_v[a] = lo_v[a] + k * c + longint'($urandom_range(0, 32'(c - 1)));
        if (hi_v[a] > 64'sd2147483647) hi_v[a] = 64'sd2147483647;
      end
      if ($urandom_range(0, 11) == 0) begin
        flip = $urandom_range(0, 2);
        c = (cell_sz[flip] == '0) ? 64'sd1 : longint'(cell_sz[flip]);
        hi_v[flip] = lo_v[flip] - c - longint'($urandom_range(0, 32'(c - 1)));
        if (hi_v[flip] < -64'sd2147483648) hi_v[flip] = -64'sd2147483648;
      end
      if ($urandom_range(0, 19) == 0) begin
        for (int a = 0; a < 3; a++) begin
          lo_v[a] = $signed($urandom);
          hi_v[a] = $signed($urandom);
        end
      end
      add_box(lo_v[0][31:0], lo_v[1][31:0], lo_v[2][31:0],
              hi_v[0][31:0], hi_v[1][31:0], hi_v[2][31:0],
              shck_pkg::PRIM_W'($urandom));
    end
  endtask

  // Box driver: next beat once the current one is taken, with idle bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || box_taken) begin
      if (tx_gap_left > 0) begin
        in_valid_i  <= 1'b0;
        tx_gap_left <= tx_gap_left - 1;
      end else if (box_queue.size() != 0 && (calm || $urandom_range(0, 9) != 0)) begin
        cur_box = box_queue.pop_front();
        in_valid_i  <= 1'b1;
        box_min_x_i <= cur_box.lo_x;
        box_min_y_i <= cur_box.lo_y;
        box_min_z_i <= cur_box.lo_z;
        box_max_x_i <= cur_box.hi_x;
        box_max_y_i <= cur_box.hi_y;
        box_max_z_i <= cur_box.hi_z;
        prim_id_i   <= cur_box.prim;
      end else begin
        in_valid_i <= 1'b0;
        if (box_queue.size() != 0) tx_gap_left <= $urandom_range(0, 9);
      end
    end
  end

  // Key receiver: long hold-off on request, else random stall bursts
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left <= rx_gap_left - 1;
      out_stall_i <= 1'b1;
      if (rx_gap_left == 1 && $urandom_range(0, 3) == 0)
        rx_free_left <= $urandom_range(20, 100);
    end else if (rx_free_left > 0) begin
      rx_free_left <= rx_free_left - 1;
      out_stall_i  <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      rx_gap_left <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each box beat, check each key beat
  always @(posedge clk_i) begin
    box_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) hash_box_keys(cur_box);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (key_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected key beat, expected none, actual key %0h tag %0h",
                 $time, bucket_key_o, prim_tag_o);
      end else begin
        cell_key_t want;
        want = key_queue.pop_front();
        check_field("bucket_key", 32'(want.bucket), 32'(bucket_key_o));
        check_field("prim_tag", 32'(want.tag), 32'(prim_tag_o));
        check_field("last_key", 32'(want.last_flag), 32'(last_key_o));
        check_field("span_clamped", 32'(want.clamped), 32'(span_clamped_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("spatial_hash_cell_keys_tb failed");
      $finish;
    end
  end

  // Sequence: reset, directed boxes, then random batches per register setting
  initial begin
    cell_sz[0]   = shck_pkg::CELL_RST;
    cell_sz[1]   = shck_pkg::CELL_RST;
    cell_sz[2]   = shck_pkg::CELL_RST;
    bucket_count = shck_pkg::TSIZE_RST;
    hash_mult[0] = shck_pkg::MULT_X_RST;
    hash_mult[1] = shck_pkg::MULT_Y_RST;
    hash_mult[2] = shck_pkg::MULT_Z_RST;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed set on the reset grid of one unit per cell
    add_box(0, 0, 0, 0, 0, 0, 16'h0000);
    add_box(-1, -1, -1, -1, -1, -1, 16'hFFFF);
    add_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'h5A5A);
    add_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hA5A5);
    add_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0001);
    // exactly four cells, then five on each axis
    add_box(0, 0, 0, 32'sh0003_FFFF, 0, 0, 16'h0002);
    add_box(0, 0, 0, 32'sh0004_FFFF, 0, 0, 16'h0003);
    add_box(0, 0, 0, 0, 32'sh0004_FFFF, 0, 16'h0004);
    add_box(0, 0, 0, 0, 0, 32'sh0004_FFFF, 16'h0005);
    // inverted axes give nothing, even with a clamp elsewhere
    add_box(0, 0, 0, -1, 0, 0, 16'h0006);
    add_box(0, 0, 0, 0, -1, 0, 16'h0007);
    add_box(0, 0, 0, 0, 0, -1, 16'h0008);
    add_box(0, 0, 0, 32'sh7FFF_FFFF, -65536, 0, 16'h0009);
    // cell boundaries and negative flooring
    add_box(65535, 65535, 65535, 65536, 65536, 65536, 16'h000A);
    add_box(-65536, -65537, -65536, -65536, -65537, -65535, 16'h000B);
    add_box(32'sh0000_8000, 0, 0, 32'sh0000_0010, 0, 0, 16'h000C);
    add_box(-32'sh0001_8000, -32'sh0001_8000, -32'sh0001_8000,
            32'sh0001_8000, 32'sh0001_8000, 32'sh0001_8000, 16'h8000);

    for (int phase = 1; phase <= 6; phase++) begin
      drain();
      case (phase)
        1: begin
          // finest grid, oversized table, degenerate multipliers
          next_cfg[shck_pkg::CFG_CELL_X] = 32'h8000_0001;
          next_cfg[shck_pkg::CFG_CELL_Y] = 32'h0000_0001;
          next_cfg[shck_pkg::CFG_CELL_Z] = 32'h0000_0001;
          next_cfg[shck_pkg::CFG_TSIZE]  = 32'hFFFF_FFFF;
          next_cfg[shck_pkg::CFG_MULT_X] = 32'hFFFF_FFFF;
          next_cfg[shck_pkg::CFG_MULT_Y] = 32'h0000_0000;
          next_cfg[shck_pkg::CFG_MULT_Z] = 32'h0000_0001;
        end
        2: begin
          // coarsest grid, zero table size
          next_cfg[shck_pkg::CFG_CELL_X] = 32'hFFFF_FFFF;
          next_cfg[shck_pkg::CFG_CELL_Y] = 32'h7FFF_FFFF;
          next_cfg[shck_pkg::CFG_CELL_Z] = 32'h7FFF_FFFF;
          next_cfg[shck_pkg::CFG_TSIZE]  = 32'h0000_0000;
          next_cfg[shck_pkg::CFG_MULT_X] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Y] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Z] = $urandom;
        end
        3: begin
          // zero cell edge on x, full table
          next_cfg[shck_pkg::CFG_CELL_X] = 32'h0000_0000;
          next_cfg[shck_pkg::CFG_CELL_Y] = 32'h0001_0000;
          next_cfg[shck_pkg::CFG_CELL_Z] = 32'h0000_0003;
          next_cfg[shck_pkg::CFG_TSIZE]  = 32'(shck_pkg::TABLE_LIMIT);
          next_cfg[shck_pkg::CFG_MULT_X] = shck_pkg::MULT_X_RST;
          next_cfg[shck_pkg::CFG_MULT_Y] = shck_pkg::MULT_Y_RST;
          next_cfg[shck_pkg::CFG_MULT_Z] = shck_pkg::MULT_Z_RST;
        end
        4: begin
          next_cfg[shck_pkg::CFG_CELL_X] = $urandom_range(1, 1 << 22);
          next_cfg[shck_pkg::CFG_CELL_Y] = $urandom_range(1, 1 << 22);
          next_cfg[shck_pkg::CFG_CELL_Z] = $urandom_range(1, 1 << 22);
          next_cfg[shck_pkg::CFG_TSIZE]  = $urandom_range(1, shck_pkg::TABLE_LIMIT);
          next_cfg[shck_pkg::CFG_MULT_X] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Y] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Z] = $urandom;
        end
        5: begin
          // single bucket; top data bit set on the cell edges
          next_cfg[shck_pkg::CFG_CELL_X] = 32'h8000_0000 |
                                           $urandom_range(16'h4000, 18'h3_FFFF);
          next_cfg[shck_pkg::CFG_CELL_Y] = 32'h8000_0000 |
                                           $urandom_range(16'h4000, 18'h3_FFFF);
          next_cfg[shck_pkg::CFG_CELL_Z] = 32'h8000_0000 |
                                           $urandom_range(16'h4000, 18'h3_FFFF);
          next_cfg[shck_pkg::CFG_TSIZE]  = 32'h0000_0001;
          next_cfg[shck_pkg::CFG_MULT_X] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Y] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Z] = $urandom;
        end
        default: begin
          next_cfg[shck_pkg::CFG_CELL_X] = $urandom_range(1, 1 << 18);
          next_cfg[shck_pkg::CFG_CELL_Y] = $urandom_range(1, 1 << 18);
          next_cfg[shck_pkg::CFG_CELL_Z] = $urandom_range(1, 1 << 18);
          next_cfg[shck_pkg::CFG_TSIZE]  = $urandom;
          next_cfg[shck_pkg::CFG_MULT_X] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Y] = $urandom;
          next_cfg[shck_pkg::CFG_MULT_Z] = $urandom;
        end
      endcase
      load_setting();
      // long receiver hold-off while boxes keep coming
      if (phase == 2) hold_seq = hold_seq + 1;
      // last batch runs with no idling on either side
      if (phase == 6) calm = 1'b1;
      queue_random_boxes(BATCH_BOXES);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("spatial_hash_cell_keys_tb passed");
    end else begin
      $display("spatial_hash_cell_keys_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/shck_pkg.sv
rtl/shck_div.sv
rtl/spatial_hash_cell_keys.sv
tb/spatial_hash_cell_keys_tb.sv
